/* design/cvj_pkg.sv */
// cvj_pkg: shared widths, codes and command/status types for the cv guided jitter generator
// depends on nothing; imported by every design module
`timescale 1ns / 1ps

package cvj_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int GAP_W      = 24;
    localparam int RAND_W     = 16;
    localparam int HEAD_W     = $clog2(MAX_WINDOW);
    localparam int CNT_W      = HEAD_W + 1;
    localparam int SUM_W      = 30;
    localparam int SQS_W      = 54;
    localparam int GSQ_W      = 2 * GAP_W;
    localparam int NQ_W       = 61;
    localparam int S1Q_W      = 2 * SUM_W;
    localparam int M1_W       = NQ_W + 10;
    localparam int DBIG_W     = 80;
    localparam int ROOT_W     = DBIG_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int CV_W       = 16;
    localparam int JIT_W      = 26;
    localparam int TGT_W      = 13;
    localparam int Y_W        = 28;
    localparam int QUO_W      = 29;
    localparam int DIVD_W     = 41;
    localparam int DSH_W      = 45;
    localparam int NB_W       = 5;
    localparam int CFG_W      = 32;
    localparam int ADDR_W     = 5;
    localparam int RIDX_W     = 3;

    localparam logic [CV_W-1:0]  CV_SAT      = '1;
    localparam logic [TGT_W-1:0] TGT_HIGH    = 13'd500;
    localparam logic [9:0]       K1000       = 10'd1000;
    localparam logic [27:0]      RECIP5      = 28'd214748365;
    localparam int               RECIP5_SH   = 30;
    localparam logic [NB_W-1:0]  NB_CV       = 5'd16;
    localparam logic [NB_W-1:0]  NB_JIT      = 5'd29;
    localparam logic [6:0]       SQ_STEPS    = 7'd40;

    localparam logic [1:0] ACT_REC = 2'd0;
    localparam logic [1:0] ACT_JIT = 2'd1;
    localparam logic [1:0] ACT_CLR = 2'd2;

    localparam logic [1:0] THR_LOW  = 2'd0;
    localparam logic [1:0] THR_MED  = 2'd1;
    localparam logic [1:0] THR_HIGH = 2'd2;
    localparam logic [1:0] THR_CRIT = 2'd3;

    localparam logic [RIDX_W-1:0] REG_ENABLE  = 3'd0;
    localparam logic [RIDX_W-1:0] REG_AUTO    = 3'd1;
    localparam logic [RIDX_W-1:0] REG_MIN_CV  = 3'd2;
    localparam logic [RIDX_W-1:0] REG_MIN_JIT = 3'd3;
    localparam logic [RIDX_W-1:0] REG_MAX_JIT = 3'd4;
    localparam logic [RIDX_W-1:0] REG_WINDOW  = 3'd5;
    localparam logic [RIDX_W-1:0] REG_THREAT  = 3'd6;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_RD_OLD,
        OP_REC_SQ,
        OP_REC_UPD,
        OP_CV_PROD,
        OP_CV_DIFF,
        OP_CV_MUL1,
        OP_CV_MUL2,
        OP_SQ_STEP,
        OP_CV_DIVST,
        OP_CV_DIVEND,
        OP_J_B1,
        OP_J_B2,
        OP_J_SPAN,
        OP_J_SCL,
        OP_J_DIVEND,
        OP_J_CLAMP
    } op_t;

    typedef struct packed {
        op_t  op;
        logic latch;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       cv_trivial;
        logic       d_pos;
        logic       sq_last;
        logic       sat;
        logic       div_done;
        logic       jit_req;
        logic       need_div;
        logic       out_free;
    } st_t;

    typedef struct packed {
        logic        enable;
        logic        boost_en;
        logic [11:0] min_cv;
        logic [23:0] min_jit;
        logic [23:0] max_jit;
        logic [6:0]  window_size;
        logic [1:0]  threat;
    } cfg_t;

endpackage

/* design/cvj_div.sv */
// cvj_div: restoring divider, one quotient bit per cycle
// depends on cvj_pkg
`timescale 1ns / 1ps

module cvj_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cvj_pkg::DIVD_W-1:0] dividend,
    input  logic [cvj_pkg::DSH_W-1:0]  dshift,
    input  logic [cvj_pkg::NB_W-1:0]   nbits,
    output logic                       busy,
    output logic                       done,
    output logic [cvj_pkg::QUO_W-1:0]  quot
);
    import cvj_pkg::*;

    logic [DIVD_W-1:0] rem_reg;
    logic [DSH_W-1:0]  dsh_reg;
    logic [NB_W-1:0]   cnt_reg;
    logic [QUO_W-1:0]  quot_reg;
    logic              busy_reg;
    logic              ge;

    assign ge   = {{(DSH_W-DIVD_W){1'b0}}, rem_reg} >= dsh_reg;
    assign busy = busy_reg;
    assign done = busy_reg && (cnt_reg == '0);
    assign quot = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dsh_reg  <= '0;
            quot_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= nbits;
            rem_reg  <= dividend;
            dsh_reg  <= dshift;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                if (ge)
                begin
                    rem_reg <= rem_reg - dsh_reg[DIVD_W-1:0];
                end
                quot_reg <= {quot_reg[QUO_W-2:0], ge};
                dsh_reg  <= dsh_reg >> 1;
                cnt_reg  <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

/* design/cvj_dp.sv */
// cvj_dp: gap ring, running sums, cv square root and jitter arithmetic, output register
// depends on cvj_pkg and cvj_div; driven by cvj_ctrl commands
`timescale 1ns / 1ps

module cvj_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cvj_pkg::cfg_t              cfg,
    input  logic                       cfg_clear,
    input  cvj_pkg::cmd_t              cmd,
    output cvj_pkg::st_t               st,
    input  logic [1:0]                 in_action,
    input  logic [cvj_pkg::GAP_W-1:0]  in_gap,
    input  logic [cvj_pkg::RAND_W-1:0] in_rand,
    input  logic                       m_tready,
    output logic                       m_tvalid,
    output logic [47:0]                m_tdata
);
    import cvj_pkg::*;

    logic [GAP_W-1:0]  ring_mem [MAX_WINDOW];
    logic [GAP_W-1:0]  ram_q;

    logic [1:0]        act_reg;
    logic [GAP_W-1:0]  gap_reg;
    logic [RAND_W-1:0] rand_reg;
    logic [HEAD_W-1:0] head_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SUM_W-1:0]  s1_reg;
    logic [SQS_W-1:0]  s2_reg;
    logic [GAP_W-1:0]  old_reg;
    logic [GSQ_W-1:0]  gsq_reg;
    logic [GSQ_W-1:0]  osq_reg;
    logic              full_reg;
    logic [NQ_W-1:0]   nq_reg;
    logic [S1Q_W-1:0]  s1q_reg;
    logic [NQ_W-1:0]   d_reg;
    logic [M1_W-1:0]   m1_reg;
    logic [DBIG_W-1:0] dbig_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [6:0]        sqcnt_reg;
    logic [CV_W-1:0]   cv_reg;
    logic [JIT_W-1:0]  emin_reg;
    logic [JIT_W-1:0]  emax_reg;
    logic [Y_W-1:0]    ymax_reg;
    logic [14:0]       ytgt_reg;
    logic              div5_reg;
    logic [TGT_W-1:0]  tgt_reg;
    logic [QUO_W-1:0]  jit_reg;
    logic              scaled_reg;
    logic              out_valid_reg;
    logic [47:0]       out_data_reg;

    logic [CNT_W-1:0]  w_eff;
    logic              full;
    logic [HEAD_W-1:0] head_nx;
    logic [REM_W+1:0]  r2;
    logic [REM_W+1:0]  trial;
    logic              sq_ge;
    logic              sat;
    logic              need_scale;
    logic              need_div;
    logic              safe;
    logic [55:0]       rmax_prod;
    logic [42:0]       rtgt_prod;
    logic [JIT_W-1:0]  span;
    logic [JIT_W+RAND_W-1:0] span_prod;
    logic [QUO_W-1:0]  jit_clamp;

    logic              div_start;
    logic              div_busy;
    logic              div_done;
    logic [DIVD_W-1:0] div_dividend;
    logic [DSH_W-1:0]  div_dshift;
    logic [NB_W-1:0]   div_nbits;
    logic [QUO_W-1:0]  div_quot;

    always_comb
    begin
        if (cfg.window_size < CNT_W'(2))
            w_eff = CNT_W'(2);
        else if (cfg.window_size > CNT_W'(MAX_WINDOW))
            w_eff = CNT_W'(MAX_WINDOW);
        else
            w_eff = cfg.window_size;
        full    = cnt_reg >= w_eff;
        head_nx = ((CNT_W'(head_reg) + 1'b1) == w_eff) ? '0 : head_reg + 1'b1;

        r2    = {rem_reg, dbig_reg[DBIG_W-1 -: 2]};
        trial = {2'b00, root_reg, 2'b01};
        sq_ge = r2 >= trial;
        sat   = {6'b0, root_reg} >= {s1_reg, 16'b0};

        need_scale = cfg.boost_en && (cnt_reg >= CNT_W'(2)) && (cv_reg != '0)
                     && (cv_reg < CV_W'(tgt_reg));
        need_div   = need_scale && !(19'(tgt_reg) >= 19'(cv_reg) * 19'd5);
        safe       = (cnt_reg < CNT_W'(2)) || (cv_reg >= CV_W'(cfg.min_cv));

        rmax_prod = 56'(ymax_reg) * 56'(RECIP5);
        rtgt_prod = 43'(ytgt_reg) * 43'(RECIP5);
        span      = emax_reg - emin_reg;
        span_prod = (JIT_W+RAND_W)'(span) * (JIT_W+RAND_W)'(rand_reg);

        if (jit_reg > QUO_W'(emax_reg))
            jit_clamp = QUO_W'(emax_reg);
        else
            jit_clamp = jit_reg;
        if (jit_clamp < QUO_W'(emin_reg))
            jit_clamp = QUO_W'(emin_reg);

        div_start = ((cmd.op == OP_CV_DIVST) && !sat) || ((cmd.op == OP_J_SCL) && need_div);
        if (cmd.op == OP_J_SCL)
        begin
            div_dividend = DIVD_W'(jit_reg[JIT_W-1:0] * 39'(tgt_reg));
            div_dshift   = DSH_W'({cv_reg, 28'b0});
            div_nbits    = NB_JIT;
        end
        else
        begin
            div_dividend = DIVD_W'(root_reg);
            div_dshift   = DSH_W'({s1_reg, 15'b0});
            div_nbits    = NB_CV;
        end
    end

    cvj_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .dshift   (div_dshift),
        .nbits    (div_nbits),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_REC_UPD)
            ring_mem[head_reg] <= gap_reg;
        if (cmd.op == OP_RD_OLD)
            ram_q <= ring_mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            cnt_reg       <= '0;
            s1_reg        <= '0;
            s2_reg        <= '0;
            act_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.latch)
            begin
                act_reg    <= in_action;
                gap_reg    <= in_gap;
                rand_reg   <= in_rand;
                jit_reg    <= '0;
                scaled_reg <= 1'b0;
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (cmd.out_load)
                out_data_reg <= {4'b0, scaled_reg, safe, cv_reg, jit_reg[JIT_W-1:0]};

            if (cfg_clear)
            begin
                head_reg <= '0;
                cnt_reg  <= '0;
                s1_reg   <= '0;
                s2_reg   <= '0;
            end
            else
            begin
                case (cmd.op)
                    OP_CLEAR:
                    begin
                        head_reg <= '0;
                        cnt_reg  <= '0;
                        s1_reg   <= '0;
                        s2_reg   <= '0;
                    end
                    OP_REC_SQ:
                    begin
                        full_reg <= full;
                        old_reg  <= full ? ram_q : '0;
                        osq_reg  <= full ? GSQ_W'(ram_q) * GSQ_W'(ram_q) : '0;
                        gsq_reg  <= GSQ_W'(gap_reg) * GSQ_W'(gap_reg);
                    end
                    OP_REC_UPD:
                    begin
                        s1_reg   <= s1_reg - SUM_W'(old_reg) + SUM_W'(gap_reg);
                        s2_reg   <= s2_reg - SQS_W'(osq_reg) + SQS_W'(gsq_reg);
                        head_reg <= head_nx;
                        if (!full_reg)
                            cnt_reg <= cnt_reg + 1'b1;
                    end
                    OP_CV_PROD:
                    begin
                        nq_reg  <= NQ_W'(cnt_reg) * NQ_W'(s2_reg);
                        s1q_reg <= S1Q_W'(s1_reg) * S1Q_W'(s1_reg);
                        cv_reg  <= '0;
                    end
                    OP_CV_DIFF:
                        d_reg <= nq_reg - NQ_W'(s1q_reg);
                    OP_CV_MUL1:
                        m1_reg <= M1_W'(d_reg) * M1_W'(K1000);
                    OP_CV_MUL2:
                    begin
                        dbig_reg  <= DBIG_W'(m1_reg * M1_W'(K1000));
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        sqcnt_reg <= SQ_STEPS;
                    end
                    OP_SQ_STEP:
                    begin
                        rem_reg   <= sq_ge ? REM_W'(r2 - trial) : REM_W'(r2);
                        root_reg  <= {root_reg[ROOT_W-2:0], sq_ge};
                        dbig_reg  <= dbig_reg << 2;
                        sqcnt_reg <= sqcnt_reg - 1'b1;
                    end
                    OP_CV_DIVST:
                        if (sat)
                            cv_reg <= CV_SAT;
                    OP_CV_DIVEND:
                        cv_reg <= div_quot[CV_W-1:0];
                    OP_J_B1:
                    begin
                        case (cfg.threat)
                            THR_MED:
                            begin
                                emin_reg <= JIT_W'(cfg.min_jit);
                                ymax_reg <= Y_W'((Y_W'(cfg.max_jit) * Y_W'(13)) >> 1);
                                ytgt_reg <= 15'(cfg.min_cv) * 15'd6;
                                div5_reg <= 1'b1;
                            end
                            THR_HIGH:
                            begin
                                emin_reg <= JIT_W'((JIT_W'(cfg.min_jit) * JIT_W'(3)) >> 1);
                                ymax_reg <= Y_W'(cfg.max_jit) * Y_W'(9);
                                ytgt_reg <= 15'(TGT_HIGH);
                                div5_reg <= 1'b1;
                            end
                            THR_CRIT:
                            begin
                                emin_reg <= JIT_W'({cfg.min_jit, 1'b0});
                                ymax_reg <= Y_W'((Y_W'(cfg.max_jit) * Y_W'(5)) >> 1);
                                ytgt_reg <= 15'(TGT_HIGH);
                                div5_reg <= 1'b0;
                            end
                            default:
                            begin
                                emin_reg <= JIT_W'(cfg.min_jit);
                                ymax_reg <= Y_W'(cfg.max_jit);
                                ytgt_reg <= 15'(cfg.min_cv);
                                div5_reg <= 1'b0;
                            end
                        endcase
                    end
                    OP_J_B2:
                    begin
                        if (div5_reg)
                        begin
                            emax_reg <= rmax_prod[RECIP5_SH +: JIT_W];
                            tgt_reg  <= (cfg.threat == THR_MED) ? rtgt_prod[RECIP5_SH +: TGT_W]
                                                                : TGT_W'(ytgt_reg);
                        end
                        else
                        begin
                            emax_reg <= ymax_reg[JIT_W-1:0];
                            tgt_reg  <= TGT_W'(ytgt_reg);
                        end
                    end
                    OP_J_SPAN:
                    begin
                        if (emax_reg > emin_reg)
                            jit_reg <= QUO_W'(emin_reg) + QUO_W'(span_prod >> RAND_W);
                        else
                            jit_reg <= QUO_W'(emin_reg);
                    end
                    OP_J_SCL:
                    begin
                        if (need_scale)
                            scaled_reg <= 1'b1;
                        if (need_scale && !need_div)
                            jit_reg <= QUO_W'(jit_reg[JIT_W-1:0] * QUO_W'(5));
                    end
                    OP_J_DIVEND:
                        jit_reg <= div_quot;
                    OP_J_CLAMP:
                        jit_reg <= jit_clamp;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        st.action     = act_reg;
        st.cv_trivial = (cnt_reg < CNT_W'(2)) || (s1_reg == '0);
        st.d_pos      = nq_reg > NQ_W'(s1q_reg);
        st.sq_last    = sqcnt_reg == 7'd1;
        st.sat        = sat;
        st.div_done   = div_done;
        st.jit_req    = (act_reg == ACT_JIT) && cfg.enable;
        st.need_div   = need_div;
        st.out_free   = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_WINDOW))
        else $error("sample count above window limit");
    a_head_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg < w_eff) |-> (CNT_W'(head_reg) == cnt_reg))
        else $error("ring head out of step with fill count");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before taken");
`endif

endmodule

/* design/cvj_ctrl.sv */
// cvj_ctrl: sequencer for record, clear, cv and jitter steps
// depends on cvj_pkg; commands cvj_dp
`timescale 1ns / 1ps

module cvj_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  cvj_pkg::st_t  st,
    output cvj_pkg::cmd_t cmd
);
    import cvj_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_RD, S_SQR, S_UPD, S_CLR, S_CV0, S_CV1, S_CV2, S_CV3,
        S_SQRT, S_CVD, S_CVW, S_JSEL, S_JB1, S_JB2, S_JSPAN, S_JSCL, S_JW, S_JCL, S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.latch    = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.latch = in_valid;
                if (in_valid)
                    state_next = S_DISP;
            end
            S_DISP:
            begin
                if (st.action == ACT_REC)
                    state_next = S_RD;
                else if (st.action == ACT_CLR)
                    state_next = S_CLR;
                else
                    state_next = S_CV0;
            end
            S_RD:
            begin
                cmd.op     = OP_RD_OLD;
                state_next = S_SQR;
            end
            S_SQR:
            begin
                cmd.op     = OP_REC_SQ;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.op     = OP_REC_UPD;
                state_next = S_CV0;
            end
            S_CLR:
            begin
                cmd.op     = OP_CLEAR;
                state_next = S_CV0;
            end
            S_CV0:
            begin
                cmd.op     = OP_CV_PROD;
                state_next = st.cv_trivial ? S_JSEL : S_CV1;
            end
            S_CV1:
            begin
                cmd.op     = OP_CV_DIFF;
                state_next = st.d_pos ? S_CV2 : S_JSEL;
            end
            S_CV2:
            begin
                cmd.op     = OP_CV_MUL1;
                state_next = S_CV3;
            end
            S_CV3:
            begin
                cmd.op     = OP_CV_MUL2;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op = OP_SQ_STEP;
                if (st.sq_last)
                    state_next = S_CVD;
            end
            S_CVD:
            begin
                cmd.op     = OP_CV_DIVST;
                state_next = st.sat ? S_JSEL : S_CVW;
            end
            S_CVW:
            begin
                if (st.div_done)
                begin
                    cmd.op     = OP_CV_DIVEND;
                    state_next = S_JSEL;
                end
            end
            S_JSEL:
                state_next = st.jit_req ? S_JB1 : S_OUT;
            S_JB1:
            begin
                cmd.op     = OP_J_B1;
                state_next = S_JB2;
            end
            S_JB2:
            begin
                cmd.op     = OP_J_B2;
                state_next = S_JSPAN;
            end
            S_JSPAN:
            begin
                cmd.op     = OP_J_SPAN;
                state_next = S_JSCL;
            end
            S_JSCL:
            begin
                cmd.op     = OP_J_SCL;
                state_next = st.need_div ? S_JW : S_JCL;
            end
            S_JW:
            begin
                if (st.div_done)
                begin
                    cmd.op     = OP_J_DIVEND;
                    state_next = S_JCL;
                end
            end
            S_JCL:
            begin
                cmd.op     = OP_J_CLAMP;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

/* design/cv_guided_jitter_generator_top.sv */
// cv_guided_jitter_generator_top: config registers, controller and datapath
// depends on cvj_pkg, cvj_ctrl, cvj_dp
//
// usage:
//   s_* stream carries one action per item: record a gap, request a jitter
//   or clear the gap history. every item returns exactly one result on m_*:
//   jitter, window cv times 1000 and two flags.
//   one item at a time: s_tready is high only while the sequencer is idle.
//   every item enters the cv steps: a record first updates the ring and sums,
//   a clear first empties the history. the cv uses a 40-step square root
//   loop and the shared one-bit-per-cycle divider (16 steps for cv, 29 steps
//   for scaling), which a jitter request that needs scaling uses once more.
//   s_tready returns the cycle after the result is loaded.
//   the result sits in an output register; a stalled m_tready holds it
//   and the sequencer waits only at the point of handing over a new result.
//   apb registers must be written only while no item is in flight; the block
//   itself does not enforce it. writing window_size empties the history.
//   reset clears history and loads the register defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module cv_guided_jitter_generator_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [39:0]                s_tdata,   // gap_us, rand_fraction
    input  logic [1:0]                 s_tuser,   // action
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [47:0]                m_tdata,   // jitter, cv_x1000, correlation_safe, cv_scaled
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cvj_pkg::ADDR_W-1:0] paddr,
    input  logic [cvj_pkg::CFG_W-1:0]  pwdata,
    output logic [cvj_pkg::CFG_W-1:0]  prdata,
    output logic                       pready
);
    import cvj_pkg::*;

    cfg_t              cfg_reg;
    logic              wr_en;
    logic [RIDX_W-1:0] ridx;
    logic              cfg_clear;
    cmd_t              cmd;
    st_t               st;

    assign pready    = 1'b1;
    assign ridx      = paddr[ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite && pready;
    assign cfg_clear = wr_en && (ridx == REG_WINDOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable      <= 1'b1;
            cfg_reg.boost_en    <= 1'b1;
            cfg_reg.min_cv      <= 12'd300;
            cfg_reg.min_jit     <= 24'd10000;
            cfg_reg.max_jit     <= 24'd100000;
            cfg_reg.window_size <= 7'd32;
            cfg_reg.threat      <= THR_LOW;
        end
        else if (wr_en)
        begin
            case (ridx)
                REG_ENABLE:  cfg_reg.enable      <= pwdata[0];
                REG_AUTO:    cfg_reg.boost_en    <= pwdata[0];
                REG_MIN_CV:  cfg_reg.min_cv      <= pwdata[11:0];
                REG_MIN_JIT: cfg_reg.min_jit     <= pwdata[23:0];
                REG_MAX_JIT: cfg_reg.max_jit     <= pwdata[23:0];
                REG_WINDOW:  cfg_reg.window_size <= pwdata[6:0];
                REG_THREAT:  cfg_reg.threat      <= pwdata[1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_ENABLE:  prdata = CFG_W'(cfg_reg.enable);
            REG_AUTO:    prdata = CFG_W'(cfg_reg.boost_en);
            REG_MIN_CV:  prdata = CFG_W'(cfg_reg.min_cv);
            REG_MIN_JIT: prdata = CFG_W'(cfg_reg.min_jit);
            REG_MAX_JIT: prdata = CFG_W'(cfg_reg.max_jit);
            REG_WINDOW:  prdata = CFG_W'(cfg_reg.window_size);
            REG_THREAT:  prdata = CFG_W'(cfg_reg.threat);
            default:     prdata = '0;
        endcase
    end

    cvj_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    cvj_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cfg_clear (cfg_clear),
        .cmd       (cmd),
        .st        (st),
        .in_action (s_tuser),
        .in_gap    (s_tdata[GAP_W-1:0]),
        .in_rand   (s_tdata[GAP_W +: RAND_W]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule
